[hdl/fvcw_pkg.sv]
`default_nettype none
package fvcw_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS = 16;
  localparam int CORDIC_PRESHIFT = 14;
  localparam int CW = 34;
  localparam int SW = 32;

  typedef struct packed {
    logic                 valid;
    logic                 xneg;
    logic                 yneg;
    logic                 xzero;
    logic                 sat;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] z;
    logic [SW-1:0]        s;
    logic [SW-1:0]        r;
  } stage_t;

  function automatic logic signed [CW-1:0] step_angle(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // anchor colors around the wheel, channel 0 red, 1 green, 2 blue
  function automatic logic [7:0] anchor(input logic [2:0] seg, input logic [1:0] ch);
    logic [23:0] rgb;
    unique case (seg)
      3'd0:    rgb = 24'hFF0000;
      3'd1:    rgb = 24'hFF00FF;
      3'd2:    rgb = 24'h4040FF;
      3'd3:    rgb = 24'h00FFFF;
      3'd4:    rgb = 24'h00FF00;
      3'd5:    rgb = 24'hFFFF00;
      3'd6:    rgb = 24'hFF0000;
      default: rgb = 24'h000000;
    endcase
    unique case (ch)
      2'd0:    return rgb[23:16];
      2'd1:    return rgb[15:8];
      default: return rgb[7:0];
    endcase
  endfunction

endpackage
`default_nettype wire

[hdl/flow_vector_color_wheel_top.sv]
`default_nettype none
// Flow vector color wheel: one (flow_x, flow_y) transaction per clock, never busy.
// Each result appears on red/green/blue with done
// high for one cycle; the receiver must take it then. The pipeline is made of
// the 28-step pipelined CORDIC (with the 16-digit square root beside it),
// three front stages for magnitude and squares, and four color stages.
module flow_vector_color_wheel_top #(
  parameter int FLOW_FRAC_BITS = 12,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] flow_x,
  input  wire logic signed [15:0] flow_y,
  output logic                    done,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);
  localparam int N = fvcw_pkg::CORDIC_STEPS;

  logic        v0, v1;
  logic        xneg0, yneg0, xzero0;
  logic        xneg1, yneg1, xzero1;
  logic [16:0] ax0, ay0, ax1, ay1;
  logic [33:0] sqx1, sqy1;
  logic [34:0] sq;

  fvcw_pkg::stage_t head;
  fvcw_pkg::stage_t chain [N+1];

  assign busy = 1'b0;
  assign sq = {1'b0, sqx1} + {1'b0, sqy1};
  assign chain[0] = head;

  always_ff @(posedge clk) begin
    ax0 <= flow_x[15] ? 17'(-$signed({flow_x[15], flow_x})) : {1'b0, flow_x};
    ay0 <= flow_y[15] ? 17'(-$signed({flow_y[15], flow_y})) : {1'b0, flow_y};
    xneg0 <= flow_x[15];
    yneg0 <= flow_y[15];
    xzero0 <= (flow_x == 16'sd0);
    ax1 <= ax0;
    ay1 <= ay0;
    sqx1 <= {17'b0, ax0} * {17'b0, ax0};
    sqy1 <= {17'b0, ay0} * {17'b0, ay0};
    xneg1 <= xneg0;
    yneg1 <= yneg0;
    xzero1 <= xzero0;
    head.valid <= v1;
    head.xneg <= xneg1;
    head.yneg <= yneg1;
    head.xzero <= xzero1;
    head.sat <= sq >= (35'(1) << (2 * FLOW_FRAC_BITS));
    head.cx <= fvcw_pkg::CW'(ax1) <<< fvcw_pkg::CORDIC_PRESHIFT;
    head.cy <= fvcw_pkg::CW'(ay1) <<< fvcw_pkg::CORDIC_PRESHIFT;
    head.z <= '0;
    head.s <= sq[31:0];
    head.r <= '0;
    v0 <= start && !busy;
    v1 <= v0;
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      head.valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    fvcw_stage #(.IDX(i)) u_stage (
      .clk(clk),
      .rst(rst),
      .d(chain[i]),
      .q(chain[i+1])
    );
  end

  fvcw_color #(
    .FLOW_FRAC_BITS(FLOW_FRAC_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_color (
    .clk(clk),
    .rst(rst),
    .d(chain[N]),
    .red(red),
    .green(green),
    .blue(blue),
    .done(done)
  );
endmodule
`default_nettype wire

[hdl/fvcw_stage.sv]
`default_nettype none
// one CORDIC vectoring step, plus one digit of the square root in the early stages
module fvcw_stage #(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fvcw_pkg::stage_t d,
  output fvcw_pkg::stage_t      q
);
  localparam logic [4:0] IDX5 = 5'(IDX);
  localparam int SQ_SHIFT = (IDX < fvcw_pkg::SQRT_STEPS) ? 30 - 2 * IDX : 0;

  fvcw_pkg::stage_t q_next;
  logic signed [fvcw_pkg::CW-1:0] dx;
  logic signed [fvcw_pkg::CW-1:0] dy;
  logic [fvcw_pkg::SW-1:0] bitv;
  logic [fvcw_pkg::SW-1:0] trial;

  always_comb begin
    q_next = d;
    dx = d.cy >>> IDX;
    dy = d.cx >>> IDX;
    if (d.cy >= 0) begin
      q_next.cx = d.cx + dx;
      q_next.cy = d.cy - dy;
      q_next.z  = d.z + fvcw_pkg::step_angle(IDX5);
    end else begin
      q_next.cx = d.cx - dx;
      q_next.cy = d.cy + dy;
      q_next.z  = d.z - fvcw_pkg::step_angle(IDX5);
    end
    bitv = '0;
    trial = '0;
    if (IDX < fvcw_pkg::SQRT_STEPS) begin
      bitv = fvcw_pkg::SW'(1) << SQ_SHIFT;
      trial = d.r + bitv;
      if (d.s >= trial) begin
        q_next.s = d.s - trial;
        q_next.r = (d.r >> 1) + bitv;
      end else begin
        q_next.r = d.r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      q.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[hdl/fvcw_color.sv]
`default_nettype none
// phase fold, segment pick, anchor mix and amplitude scale
module fvcw_color #(
  parameter int FLOW_FRAC_BITS = 12,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fvcw_pkg::stage_t d,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  done
);
  localparam int A  = ANGLE_BITS;
  localparam int F  = FLOW_FRAC_BITS;
  localparam int MW = A + 6;
  localparam int PW = F + 1 + MW;

  logic [30:0]   zc;
  logic [31:0]   rsum;
  logic [A-1:0]  t;
  logic [A-1:0]  a;
  logic [2:0]    hi;
  logic [2:0]    seg_next;
  logic [A-3:0]  n2_next;
  logic [F:0]    amp_next;

  // stage 1
  logic          v1;
  logic [2:0]    seg1;
  logic [A-3:0]  n1;
  logic [F:0]    amp1;
  // stage 2
  logic          v2;
  logic [F:0]    amp2;
  logic [MW-1:0] mix2 [3];
  // stage 3
  logic          v3;
  logic [F:0]    amp3;
  logic [PW-1:0] prod3 [3];

  always_comb begin
    if (d.z < 0) begin
      zc = '0;
    end else if (d.z > (fvcw_pkg::CW'(1) <<< 30)) begin
      zc = 31'(1) << 30;
    end else begin
      zc = d.z[30:0];
    end
    rsum = {1'b0, zc} + (32'(1) << (31 - A));
    t = rsum[31:32-A];
    if (d.xzero) begin
      a = d.yneg ? A'(3) << (A - 2) : A'(1) << (A - 2);
    end else if (!d.xneg) begin
      a = d.yneg ? A'(0) - t : t;
    end else begin
      a = d.yneg ? (A'(1) << (A - 1)) + t : (A'(1) << (A - 1)) - t;
    end
    hi = a[A-1:A-3];
    unique case (hi)
      3'd0, 3'd1, 3'd2, 3'd3: begin
        seg_next = hi;
        n2_next = {a[A-4:0], 1'b0};
      end
      3'd4, 3'd5: begin
        seg_next = 3'd4;
        n2_next = {hi[0], a[A-4:0]};
      end
      default: begin
        seg_next = 3'd5;
        n2_next = {hi[0], a[A-4:0]};
      end
    endcase
    amp_next = d.sat ? (F + 1)'(1) << F : d.r[F:0];
  end

  always_ff @(posedge clk) begin
    seg1 <= seg_next;
    n1 <= n2_next;
    amp1 <= amp_next;
    amp2 <= amp1;
    amp3 <= amp2;
    for (int c = 0; c < 3; c++) begin
      mix2[c] <= MW'(fvcw_pkg::anchor(seg1, 2'(c)))
                   * MW'(((A - 1)'(1) << (A - 2)) - (A - 1)'(n1))
               + MW'(fvcw_pkg::anchor(seg1 + 3'd1, 2'(c))) * MW'(n1);
      prod3[c] <= PW'(amp2) * PW'(mix2[c]);
    end
    red   <= prod3[0][F+A-2 +: 8];
    green <= prod3[1][F+A-2 +: 8];
    blue  <= prod3[2][F+A-2 +: 8];
    v1 <= d.valid;
    v2 <= v1;
    v3 <= v2;
    done <= v3;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(d.valid, 4))
    else $error("result strobe without a transaction four cycles back");
  a_black: assert property (@(posedge clk) disable iff (rst)
    (v3 && amp3 == '0) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("zero amplitude gave a nonblack color");
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (seg1 <= 3'd5))
    else $error("segment out of range");
endmodule
`default_nettype wire
